// ===== sv/scsr_pkg.sv =====
// Shared types and constants for the scan code screen router.
`timescale 1ns / 1ps
`default_nettype none
package scsr_pkg;

  localparam int SCREEN_COUNT_DEF = 4;
  localparam int QUEUE_DEPTH_DEF  = 16;

  // F1..F4 select a screen instead of being queued
  localparam logic [7:0] SWITCH_FIRST = 8'h3B;
  localparam logic [7:0] SWITCH_LAST  = 8'h3E;

  localparam logic ACT_ARRIVE = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] scan_code;
    logic [1:0] screen;
  } scsr_in_t;

  typedef struct packed {
    logic       key_valid;
    logic [7:0] key;
    logic       dropped;
    logic [1:0] current_screen;
    logic [1:0] previous_screen;
    logic       still_available;
  } scsr_out_t;

endpackage
`default_nettype wire

// ===== sv/scsr_chan_if.sv =====
// Valid/ready channel interface carrying one word of a given payload type.
`timescale 1ns / 1ps
`default_nettype none
interface scsr_chan_if #(
  parameter type PAYLOAD_T = logic
);
  logic     valid;
  logic     ready;
  PAYLOAD_T payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== sv/scan_code_screen_router_fifos.sv =====
// Top level: per-screen scan code queues with screen switching on F1..F4.
`timescale 1ns / 1ps
`default_nettype none
// Keeps one FIFO of keyboard scan codes per virtual screen in a single code
// RAM, with per-screen read pointers and fill counts in flops. An arrival of
// F1..F4 switches screens; any other arriving code joins the current screen's
// queue or is dropped (flagged) when it is full. A read pops the oldest code of
// the named screen, or returns key_valid low and key zero when it is empty.
// Throughput is one word per cycle while the output is not stalled; each result
// passes through the s1 stage, which also takes the registered read of the code
// RAM, and then the output register. Pointer and count updates happen at
// acceptance, so back-to-back items always see the state left by the previous
// one. Only screens 0..3 can be addressed through the 2-bit screen fields.
module scan_code_screen_router_fifos #(
  parameter int SCREEN_COUNT = scsr_pkg::SCREEN_COUNT_DEF,
  parameter int QUEUE_DEPTH  = scsr_pkg::QUEUE_DEPTH_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  scsr_chan_if.sink   in_chan,
  scsr_chan_if.source out_chan
);
  import scsr_pkg::*;

  localparam int SCR_W  = $clog2(SCREEN_COUNT);
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int RAM_D  = SCREEN_COUNT * QUEUE_DEPTH;
  localparam int ADDR_W = $clog2(RAM_D);

  logic [PTR_W-1:0] rp_r  [SCREEN_COUNT];
  logic [CNT_W-1:0] cnt_r [SCREEN_COUNT];
  logic [1:0]       sel_r, sel_nxt;
  logic [1:0]       prev_r, prev_nxt;

  logic             s1_valid_r;
  logic             s1_pop_r;
  logic             s1_dropped_r;
  logic             s1_avail_r;
  logic [1:0]       s1_cur_r;
  logic [1:0]       s1_prev_r;

  logic             out_valid_r;
  scsr_out_t        out_data_r;

  scsr_in_t         in_w;
  logic             in_fire;
  logic             is_read;
  logic             is_switch;
  logic [1:0]       new_scr;
  logic [1:0]       idx2;
  logic [SCR_W-1:0] idx;
  logic [PTR_W-1:0] rp;
  logic [CNT_W-1:0] cnt;
  logic             full;
  logic             pop;
  logic             push;
  logic             avail;
  logic [PTR_W:0]   wp_sum;
  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] rp_inc;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]       ram_rdata;
  logic             s1_move;

  assign in_w    = in_chan.payload;
  assign s1_move = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_move;
  assign in_fire = in_chan.valid && in_chan.ready;

  assign is_read   = (in_w.action == ACT_READ);
  assign is_switch = !is_read && (in_w.scan_code >= SWITCH_FIRST) &&
                     (in_w.scan_code <= SWITCH_LAST);
  assign new_scr   = 2'(in_w.scan_code - SWITCH_FIRST);

  // one queue is touched per word: the named one, the new one or the current one
  always_comb begin
    if (is_read) begin
      idx2 = in_w.screen;
    end else if (is_switch) begin
      idx2 = new_scr;
    end else begin
      idx2 = sel_r;
    end
  end

  assign idx  = SCR_W'(idx2);
  assign rp   = rp_r[idx];
  assign cnt  = cnt_r[idx];
  assign full = (cnt == CNT_W'(QUEUE_DEPTH));
  assign pop  = is_read && (cnt != '0);
  assign push = !is_read && !is_switch && !full;
  assign avail = is_read ? (cnt > CNT_W'(1)) : (push || (cnt != '0));

  // rp and cnt are both below the depth when pushing, so one subtract wraps
  assign wp_sum = (PTR_W+1)'(rp) + (PTR_W+1)'(cnt[PTR_W-1:0]);
  assign wp     = (wp_sum >= (PTR_W+1)'(QUEUE_DEPTH)) ?
                  PTR_W'(wp_sum - (PTR_W+1)'(QUEUE_DEPTH)) : PTR_W'(wp_sum);
  assign rp_inc = (rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rp + PTR_W'(1));

  assign base  = ADDR_W'(idx) * ADDR_W'(QUEUE_DEPTH);
  assign waddr = base + ADDR_W'(wp);
  assign raddr = base + ADDR_W'(rp);

  always_comb begin
    sel_nxt  = sel_r;
    prev_nxt = prev_r;
    if (in_fire && is_switch) begin
      prev_nxt = sel_r;
      sel_nxt  = new_scr;
    end
  end

  scsr_ram #(
    .WIDTH (8),
    .DEPTH (RAM_D)
  ) u_code_ram (
    .clk   (clk),
    .we    (in_fire && push),
    .waddr (waddr),
    .wdata (in_w.scan_code),
    .re    (in_fire && pop),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SCREEN_COUNT; i++) begin
        rp_r[i]  <= '0;
        cnt_r[i] <= '0;
      end
      sel_r       <= '0;
      prev_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sel_r  <= sel_nxt;
      prev_r <= prev_nxt;
      if (in_fire && pop) begin
        rp_r[idx]  <= rp_inc;
        cnt_r[idx] <= cnt - CNT_W'(1);
      end else if (in_fire && push) begin
        cnt_r[idx] <= cnt + CNT_W'(1);
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pop_r     <= pop;
      s1_dropped_r <= !is_read && !is_switch && full;
      s1_avail_r   <= avail;
      s1_cur_r     <= sel_nxt;
      s1_prev_r    <= prev_nxt;
    end
    if (s1_move) begin
      out_data_r.key_valid       <= s1_pop_r;
      out_data_r.key             <= s1_pop_r ? ram_rdata : 8'h00;
      out_data_r.dropped         <= s1_dropped_r;
      out_data_r.current_screen  <= s1_cur_r;
      out_data_r.previous_screen <= s1_prev_r;
      out_data_r.still_available <= s1_avail_r;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_data_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt <= CNT_W'(QUEUE_DEPTH))
    else $error("queue fill count above depth");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_chan.ready) |-> !in_chan.ready)
    else $error("input accepted while pipeline is blocked");

  a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_read && (cnt == '0)) |=> (!s1_pop_r && !s1_avail_r))
    else $error("read of empty queue produced a code");

  a_no_key_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.key_valid) |-> (out_data_r.key == 8'h00))
    else $error("key nonzero without key_valid");
`endif

endmodule
`default_nettype wire

// ===== sv/scsr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module scsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire
